// ===== design/pidpi_pkg.sv =====
// Shared constants, configuration codes and structures of the PID unit.
package pidpi_pkg;

    localparam int FRAC_BITS = 12;
    localparam int DATA_W    = 16;
    localparam int GAIN_W    = 16;
    localparam int LIMIT_W   = 15;
    localparam int ERR_W     = DATA_W + 1;
    localparam int ACC_W     = 32;
    localparam int SUM_W     = GAIN_W + ERR_W + 5;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE         = 3'd0,
        CFG_GAIN_P       = 3'd1,
        CFG_GAIN_I       = 3'd2,
        CFG_GAIN_D       = 3'd3,
        CFG_OUTPUT_LIMIT = 3'd4,
        CFG_INTEG_CLAMP  = 3'd5
    } t_cfg_index;

    localparam logic MODE_POSITIONAL  = 1'b0;
    localparam logic MODE_INCREMENTAL = 1'b1;

    typedef struct packed {
        logic                      mode;
        logic signed [GAIN_W-1:0]  gain_p;
        logic signed [GAIN_W-1:0]  gain_i;
        logic signed [GAIN_W-1:0]  gain_d;
        logic        [LIMIT_W-1:0] output_limit;
        logic        [LIMIT_W-1:0] integ_clamp;
    } t_cfg;

    typedef struct packed {
        logic signed [DATA_W-1:0] drive;
        logic                     limited;
    } t_result;

endpackage

// ===== design/pidpi_ifs.sv =====
// Handshake channel interfaces of the PID unit: samples, results and configuration.
interface pidpi_sample_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [pidpi_pkg::DATA_W-1:0]  measured;
    logic signed [pidpi_pkg::DATA_W-1:0]  setpoint;

    modport source (output valid, output measured, output setpoint, input ready);
    modport sink   (input valid, input measured, input setpoint, output ready);
endinterface

interface pidpi_result_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [pidpi_pkg::DATA_W-1:0]  drive;
    logic                                 limited;

    modport source (output valid, output drive, output limited, input ready);
    modport sink   (input valid, input drive, input limited, output ready);
endinterface

interface pidpi_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [pidpi_pkg::CFG_IDX_W-1:0]      index;
    logic [pidpi_pkg::DATA_W-1:0]         data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/pid_position_incremental_unit.sv =====
// Top level of the PID unit: sample register, PID pass and result register.
// Flow: a sample waits in the sample register, and its result is registered in the result register when it advances.
// Throughput: one sample per cycle while the result register is free or drained; the single registered pass
// through the three multipliers, sums and clamps closes the state loop on each advance.
// Reset: synchronous, active low; clears both stages, error history, integral
// and held output, and loads the default configuration.
module pid_position_incremental_unit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    pidpi_sample_if.sink     i_sample,
    pidpi_cfg_if.sink        i_cfg,
    pidpi_result_if.source   o_result
);

    pidpi_pkg::t_cfg    w_cfg;
    pidpi_pkg::t_result w_core_result;
    pidpi_pkg::t_result r_out;

    logic                                 r_in_valid;
    logic signed [pidpi_pkg::DATA_W-1:0]  r_measured;
    logic signed [pidpi_pkg::DATA_W-1:0]  r_setpoint;
    logic                                 r_out_valid;
    logic                                 w_advance;
    logic                                 w_in_ready;

    pidpi_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    pidpi_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_advance  (w_advance),
        .i_measured (r_measured),
        .i_setpoint (r_setpoint),
        .o_result   (w_core_result)
    );

    // Advance when the result register is free or being drained this cycle
    assign w_advance  = r_in_valid && (!r_out_valid || o_result.ready);
    assign w_in_ready = !r_in_valid || w_advance;

    assign i_sample.ready   = w_in_ready;
    assign o_result.valid   = r_out_valid;
    assign o_result.drive   = r_out.drive;
    assign o_result.limited = r_out.limited;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_ready) begin
                r_in_valid <= i_sample.valid;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_ready && i_sample.valid) begin
            r_measured <= i_sample.measured;
            r_setpoint <= i_sample.setpoint;
        end
        if (w_advance) begin
            r_out <= w_core_result;
        end
    end

    a_no_result_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_result.valid)
        else $error("result valid straight after reset");

    a_drive_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> (o_result.drive != 16'sh8000))
        else $error("drive outside the symmetric output range");

    a_full_transfer_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_sample.valid && i_sample.ready && r_in_valid) |-> w_advance)
        else $error("sample transfer into an occupied stage without advance");

    a_stalled_result_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_result.ready) |=> (r_out_valid && $stable(r_out)))
        else $error("waiting result lost or changed");

endmodule

// ===== design/pidpi_cfg_regs.sv =====
// Configuration register bank of the PID unit.
module pidpi_cfg_regs (
    input  logic                i_clk,
    input  logic                i_rst_n,
    pidpi_cfg_if.sink           i_cfg,
    output pidpi_pkg::t_cfg     o_cfg
);

    pidpi_pkg::t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode         <= pidpi_pkg::MODE_INCREMENTAL;
            r_cfg.gain_p       <= '0;
            r_cfg.gain_i       <= '0;
            r_cfg.gain_d       <= '0;
            r_cfg.output_limit <= '1;
            r_cfg.integ_clamp  <= '1;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                pidpi_pkg::CFG_MODE:           r_cfg.mode   <= i_cfg.data[0];
                pidpi_pkg::CFG_GAIN_P:         r_cfg.gain_p <= $signed(i_cfg.data);
                pidpi_pkg::CFG_GAIN_I:         r_cfg.gain_i <= $signed(i_cfg.data);
                pidpi_pkg::CFG_GAIN_D:         r_cfg.gain_d <= $signed(i_cfg.data);
                pidpi_pkg::CFG_OUTPUT_LIMIT:
                    r_cfg.output_limit <= i_cfg.data[pidpi_pkg::LIMIT_W-1:0];
                pidpi_pkg::CFG_INTEG_CLAMP:
                    r_cfg.integ_clamp <= i_cfg.data[pidpi_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

// ===== design/pidpi_core.sv =====
// PID arithmetic for one sample, with error history, integral and held output state.
module pidpi_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  pidpi_pkg::t_cfg                      i_cfg,
    input  logic                                 i_advance,
    input  logic signed [pidpi_pkg::DATA_W-1:0]  i_measured,
    input  logic signed [pidpi_pkg::DATA_W-1:0]  i_setpoint,
    output pidpi_pkg::t_result                   o_result
);

    localparam int ERR_W  = pidpi_pkg::ERR_W;
    localparam int GAIN_W = pidpi_pkg::GAIN_W;
    localparam int ACC_W  = pidpi_pkg::ACC_W;
    localparam int SUM_W  = pidpi_pkg::SUM_W;
    localparam int FRAC   = pidpi_pkg::FRAC_BITS;
    localparam int DATA_W = pidpi_pkg::DATA_W;
    localparam logic [ACC_W:0] TRUNC_BIAS = (ACC_W+1)'((1 << FRAC) - 1);

    typedef struct packed {
        logic signed [SUM_W-1:0] value;
        logic                    hit;
    } t_clamp;

    logic signed [ERR_W-1:0] r_err_prev;
    logic signed [ERR_W-1:0] r_err_prev2;
    logic signed [ACC_W-1:0] r_integral;
    logic signed [ACC_W-1:0] r_held;

    logic signed [ERR_W-1:0]          w_err;
    logic signed [ERR_W:0]            w_diff1;
    logic signed [ERR_W+1:0]          w_diff2;
    logic signed [ERR_W:0]            w_p_op;
    logic signed [ERR_W+1:0]          w_d_op;
    logic signed [GAIN_W+ERR_W:0]     w_p_prod;
    logic signed [GAIN_W+ERR_W-1:0]   w_i_prod;
    logic signed [GAIN_W+ERR_W+1:0]   w_d_prod;
    logic signed [SUM_W-1:0]          w_ilim;
    logic signed [SUM_W-1:0]          w_olim;
    logic signed [SUM_W-1:0]          w_i_pre;
    logic signed [SUM_W-1:0]          w_base;
    logic signed [SUM_W-1:0]          w_sum;
    t_clamp                           w_i_clamp;
    t_clamp                           w_o_clamp;
    logic signed [ACC_W-1:0]          w_i_new;
    logic signed [ACC_W-1:0]          w_out_val;
    logic        [ACC_W:0]            w_adj;
    logic                             w_incr;

    function automatic t_clamp clamp_sym(input logic signed [SUM_W-1:0] x,
                                         input logic signed [SUM_W-1:0] lim);
        t_clamp c;
        c.hit = 1'b1;
        if (x > lim) begin
            c.value = lim;
        end else if (x < -lim) begin
            c.value = -lim;
        end else begin
            c.value = x;
            c.hit   = 1'b0;
        end
        return c;
    endfunction

    always_comb begin
        w_incr  = (i_cfg.mode == pidpi_pkg::MODE_INCREMENTAL);
        w_err   = ERR_W'(i_setpoint) - ERR_W'(i_measured);
        w_diff1 = (ERR_W+1)'(w_err) - (ERR_W+1)'(r_err_prev);
        w_diff2 = (ERR_W+2)'(w_err) - ((ERR_W+2)'(r_err_prev) <<< 1)
                + (ERR_W+2)'(r_err_prev2);

        // Incremental mode shifts every term down one difference order
        w_p_op = w_incr ? w_diff1 : (ERR_W+1)'(w_err);
        w_d_op = w_incr ? w_diff2 : (ERR_W+2)'(w_diff1);

        w_p_prod = i_cfg.gain_p * w_p_op;
        w_i_prod = i_cfg.gain_i * w_err;
        w_d_prod = i_cfg.gain_d * w_d_op;

        w_ilim = $signed(SUM_W'(i_cfg.integ_clamp) << FRAC);
        w_olim = $signed(SUM_W'(i_cfg.output_limit) << FRAC);

        w_i_pre   = w_incr ? SUM_W'(w_i_prod) : SUM_W'(r_integral) + SUM_W'(w_i_prod);
        w_i_clamp = clamp_sym(w_i_pre, w_ilim);
        w_i_new   = w_i_clamp.value[ACC_W-1:0];

        w_base    = w_incr ? SUM_W'(r_held) : '0;
        w_sum     = w_base + SUM_W'(w_p_prod) + SUM_W'(w_i_new) + SUM_W'(w_d_prod);
        w_o_clamp = clamp_sym(w_sum, w_olim);
        w_out_val = w_o_clamp.value[ACC_W-1:0];

        // Bias negative values so the shift truncates toward zero
        w_adj = {w_out_val[ACC_W-1], w_out_val}
              + (w_out_val[ACC_W-1] ? TRUNC_BIAS : '0);

        o_result.drive   = $signed(w_adj[FRAC+DATA_W-1:FRAC]);
        o_result.limited = w_o_clamp.hit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err_prev  <= '0;
            r_err_prev2 <= '0;
            r_integral  <= '0;
            r_held      <= '0;
        end else if (i_advance) begin
            r_err_prev  <= w_err;
            r_err_prev2 <= r_err_prev;
            r_integral  <= w_i_new;
            if (w_incr) begin
                r_held <= w_out_val;
            end
        end
    end

endmodule
